// ===== sv/frg_pkg.sv =====
package frg_pkg;

	localparam int WIDTH = 32;
	localparam int CNT_W = $clog2(WIDTH);

	typedef logic [WIDTH-1:0] word_t;
	typedef logic signed [WIDTH-1:0] sword_t;
	typedef logic [WIDTH-2:0] dword_t;

	localparam word_t MAG_LIMIT = {1'b0, {(WIDTH-1){1'b1}}};

	typedef struct packed {
		logic load;
		logic euc_start;
		logic num_start;
		logic den_start;
		logic euc_update;
		logic store_rn;
		logic store_rd;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic zz;
		logic b_zero;
		logic div_done;
	} stat_t;

endpackage

// ===== sv/frg_if.sv =====
interface frg_in_if;
	logic valid;
	logic ready;
	frg_pkg::sword_t numerator_in;
	frg_pkg::sword_t denominator_in;

	modport source(output valid, output numerator_in, output denominator_in, input ready);
	modport sink(input valid, input numerator_in, input denominator_in, output ready);
endinterface

interface frg_out_if;
	logic valid;
	logic ready;
	frg_pkg::sword_t numerator_out;
	frg_pkg::dword_t denominator_out;
	logic zero_over_zero;

	modport source(output valid, output numerator_out, output denominator_out,
		output zero_over_zero, input ready);
	modport sink(input valid, input numerator_out, input denominator_out,
		input zero_over_zero, output ready);
endinterface

// ===== sv/frg_div.sv =====
module frg_div (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  frg_pkg::word_t dividend,
	input  frg_pkg::word_t divisor,
	output frg_pkg::word_t quotient,
	output frg_pkg::word_t remainder,
	output logic           done
);

	logic busy_q;
	logic done_q;
	logic [frg_pkg::CNT_W-1:0] cnt_q;
	frg_pkg::word_t rem_q;
	frg_pkg::word_t quo_q;
	frg_pkg::word_t dsr_q;

	logic [frg_pkg::WIDTH:0] trial;
	logic [frg_pkg::WIDTH:0] diff;
	logic ge;
	logic last;

	// Restoring division: one quotient bit per cycle, most significant first.
	assign trial = {rem_q, quo_q[frg_pkg::WIDTH-1]};
	assign diff = trial - {1'b0, dsr_q};
	assign ge = !diff[frg_pkg::WIDTH];
	assign last = (cnt_q == frg_pkg::CNT_W'(frg_pkg::WIDTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[frg_pkg::WIDTH-1:0] : trial[frg_pkg::WIDTH-1:0];
			quo_q <= {quo_q[frg_pkg::WIDTH-2:0], ge};
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
	assign done = done_q;

endmodule

// ===== sv/frg_datapath.sv =====
module frg_datapath (
	input  logic            clk,
	input  logic            arst_n,
	input  frg_pkg::sword_t num_in,
	input  frg_pkg::sword_t den_in,
	input  frg_pkg::cmd_t   cmd,
	output frg_pkg::stat_t  stat,
	output frg_pkg::sword_t num_out,
	output frg_pkg::dword_t den_out,
	output logic            zz_out
);

	frg_pkg::word_t nm_q;
	frg_pkg::word_t dm_q;
	logic nneg_q;
	logic dneg_q;
	logic zz_q;
	frg_pkg::word_t a_q;
	frg_pkg::word_t b_q;
	frg_pkg::word_t rn_q;
	frg_pkg::word_t rd_q;
	frg_pkg::sword_t num_q;
	frg_pkg::dword_t den_q;
	logic zzo_q;

	frg_pkg::word_t n_mag;
	frg_pkg::word_t d_mag;
	frg_pkg::word_t div_dividend;
	frg_pkg::word_t div_divisor;
	frg_pkg::word_t quo;
	frg_pkg::word_t rem;
	logic div_start;
	logic div_done;
	frg_pkg::word_t rn_sat;
	frg_pkg::word_t rd_sat;
	logic neg;

	assign n_mag = num_in[frg_pkg::WIDTH-1] ? (~frg_pkg::word_t'(num_in) + 1'b1)
		: frg_pkg::word_t'(num_in);
	assign d_mag = den_in[frg_pkg::WIDTH-1] ? (~frg_pkg::word_t'(den_in) + 1'b1)
		: frg_pkg::word_t'(den_in);

	assign div_start = cmd.euc_start || cmd.num_start || cmd.den_start;

	// After the Euclid loop a_q holds the common divisor.
	always_comb begin
		priority if (cmd.num_start) begin
			div_dividend = nm_q;
			div_divisor = a_q;
		end else if (cmd.den_start) begin
			div_dividend = dm_q;
			div_divisor = a_q;
		end else begin
			div_dividend = a_q;
			div_divisor = b_q;
		end
	end

	frg_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.quotient(quo),
		.remainder(rem),
		.done(div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			nm_q <= n_mag;
			dm_q <= d_mag;
			nneg_q <= num_in[frg_pkg::WIDTH-1];
			dneg_q <= den_in[frg_pkg::WIDTH-1];
			zz_q <= stat.zz;
			a_q <= n_mag;
			b_q <= d_mag;
		end else if (cmd.euc_update) begin
			a_q <= b_q;
			b_q <= rem;
		end
		if (cmd.store_rn) begin
			rn_q <= quo;
		end
		if (cmd.store_rd) begin
			rd_q <= quo;
		end
	end

	// Only the most negative input can give a magnitude past the limit.
	assign rn_sat = rn_q[frg_pkg::WIDTH-1] ? frg_pkg::MAG_LIMIT : rn_q;
	assign rd_sat = rd_q[frg_pkg::WIDTH-1] ? frg_pkg::MAG_LIMIT : rd_q;
	assign neg = (nneg_q != dneg_q) && (rn_q != '0);

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			if (zz_q) begin
				num_q <= '0;
				den_q <= '0;
				zzo_q <= 1'b1;
			end else begin
				num_q <= frg_pkg::sword_t'(neg ? (~rn_sat + 1'b1) : rn_sat);
				den_q <= rd_sat[frg_pkg::WIDTH-2:0];
				zzo_q <= 1'b0;
			end
		end
	end

	assign stat.zz = (num_in == '0) && (den_in == '0);
	assign stat.b_zero = (b_q == '0);
	assign stat.div_done = div_done;

	assign num_out = num_q;
	assign den_out = den_q;
	assign zz_out = zzo_q;

endmodule

// ===== sv/frg_ctrl.sv =====
module frg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  frg_pkg::stat_t stat,
	output frg_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		IDLE,
		EUC_TEST,
		EUC_DIV,
		NUM_DIV,
		DEN_DIV,
		FINISH
	} state_t;

	state_t state_q;
	logic out_valid_q;
	logic can_emit;

	assign in_ready = (state_q == IDLE);
	assign can_emit = !out_valid_q || out_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			IDLE: cmd.load = in_valid;
			EUC_TEST: begin
				cmd.num_start = stat.b_zero;
				cmd.euc_start = !stat.b_zero;
			end
			EUC_DIV: cmd.euc_update = stat.div_done;
			NUM_DIV: begin
				cmd.store_rn = stat.div_done;
				cmd.den_start = stat.div_done;
			end
			DEN_DIV: cmd.store_rd = stat.div_done;
			FINISH: cmd.emit = can_emit;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// A new word replaces the one leaving in the same cycle.
			if (state_q == FINISH && can_emit) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						state_q <= stat.zz ? FINISH : EUC_TEST;
					end
				end
				EUC_TEST: state_q <= stat.b_zero ? NUM_DIV : EUC_DIV;
				EUC_DIV: begin
					if (stat.div_done) begin
						state_q <= EUC_TEST;
					end
				end
				NUM_DIV: begin
					if (stat.div_done) begin
						state_q <= DEN_DIV;
					end
				end
				DEN_DIV: begin
					if (stat.div_done) begin
						state_q <= FINISH;
					end
				end
				FINISH: begin
					if (can_emit) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== sv/fraction_reduce_gcd.sv =====
// Fraction reducer: takes a signed fraction on in_ch and returns it in lowest
// terms on out_ch, with the sign on the numerator and a non-negative
// denominator. Zero over zero returns 0/0 with zero_over_zero set; a nonzero
// value over zero returns +1/0 or -1/0; zero over a nonzero value returns 0/1.
// Both channels are valid/ready; a word moves when valid and ready are high
// at a rising edge of clk.
// One fraction is worked on at a time. The greatest common divisor comes from
// a Euclid loop whose steps each run one remainder through a shared restoring
// divider; two more divider passes then divide both parts. Zero over zero
// skips the divider and goes straight to the output. A new fraction is taken
// only once the last one has reached the output register.
// The result waits in an output register, so in_ch takes the next fraction
// while out_ch is stalled; that fraction then holds until the register frees.
// arst_n clears the controller and the output valid; no result is pending
// after reset.
module fraction_reduce_gcd (
	input logic       clk,
	input logic       arst_n,
	frg_in_if.sink    in_ch,
	frg_out_if.source out_ch
);

	frg_pkg::cmd_t cmd;
	frg_pkg::stat_t stat;

	frg_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_ch.valid),
		.in_ready(in_ch.ready),
		.out_valid(out_ch.valid),
		.out_ready(out_ch.ready),
		.stat(stat),
		.cmd(cmd)
	);

	frg_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.num_in(in_ch.numerator_in),
		.den_in(in_ch.denominator_in),
		.cmd(cmd),
		.stat(stat),
		.num_out(out_ch.numerator_out),
		.den_out(out_ch.denominator_out),
		.zz_out(out_ch.zero_over_zero)
	);

endmodule

// ===== sv/frg_checker.sv =====
module frg_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            out_valid,
	input logic            out_ready,
	input frg_pkg::sword_t num_out,
	input frg_pkg::dword_t den_out,
	input logic            zz_out
);

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output valid dropped while stalled");

	a_payload_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(num_out) && $stable(den_out) && $stable(zz_out))
		else $error("output word changed while stalled");

	a_zz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && zz_out |-> num_out == '0 && den_out == '0)
		else $error("zero over zero result is not 0/0");

	a_div_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zz_out && den_out == '0 |-> num_out == 1 || num_out == -1)
		else $error("fraction over zero did not reduce to +1/0 or -1/0");

	a_num_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !zz_out && num_out == '0 |-> den_out == 1)
		else $error("zero numerator did not reduce to 0/1");

endmodule

bind fraction_reduce_gcd frg_checker u_frg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.num_out(out_ch.numerator_out),
	.den_out(out_ch.denominator_out),
	.zz_out(out_ch.zero_over_zero)
);
